>>> design/gto_pkg.sv
// shared types and constants for the gps track odometer
package gto_pkg;

   localparam int unsigned CoordWidth = 24;
   localparam int unsigned DiffWidth  = 25;
   localparam int unsigned SqWidth    = 50;
   localparam int unsigned RootWidth  = 25;
   localparam int unsigned AccWidth   = 48;
   localparam int unsigned CountWidth = 32;
   localparam int unsigned RemWidth   = 33;

   localparam logic [5:0] RootSteps = 6'd25;
   localparam logic [5:0] DivSteps  = 6'd48;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_DATA  = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_OTHER = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_ROOT_WAIT,
      ST_DIV,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PASS_STEP,
      PASS_RADIUS,
      PASS_END
   } pass_type;

   typedef enum logic {
      MODE_ROOT,
      MODE_DIV
   } alu_mode_type;

   localparam logic [AccWidth-1:0]   AccMax   = '1;
   localparam logic [CountWidth-1:0] CountMax = '1;

endpackage

>>> design/gps_track_odometer.sv
// gps track odometer top level: state, sequencer and output register
// work per item: for an item that is not counted, the end distance root only;
// for a counted sample, three roots (step, radius, end distance) and one divide
// each root pass is two squares, load, 25 steps, drain; the divide follows the roots
// one item at a time, req_tready high only in idle; a result waits in done while rsp_tready is low
// synchronous active-high reset clears all state to zero, except pass_ff, which resets to PASS_END
module gps_track_odometer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // command[1:0], pos_x[25:2], pos_y[49:26], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata    // end_x, end_y, path_length, end_to_start,
                                     // mean_to_start, tracking, zero pad
);

   logic [23:0] org_x_ff, org_y_ff, lst_x_ff, lst_y_ff, stp_x_ff, stp_y_ff;
   logic [23:0] in_x_ff, in_y_ff;
   logic        act_ff;
   logic [47:0] path_ff, rad_ff;
   logic [31:0] cnt_ff;
   logic [24:0] e2s_ff, mean_ff;
   logic        count_ff;
   gto_pkg::state_type state_ff, state_in;
   gto_pkg::pass_type  pass_ff, pass_in;
   logic        rsp_v_ff;
   logic [146:0] rsp_data_ff;

   logic [23:0] ax, ay, bx, by;
   logic [24:0] dx, dy, mag;
   logic        sq_load, sq_add, root_start, div_start, busy;
   logic [24:0] root;
   logic [47:0] quot;
   logic [48:0] path_sum, rad_sum;
   logic        accept;
   logic        is_sample;
   gto_pkg::command_type req_cmd;

   assign req_cmd    = gto_pkg::command_type'(req_tdata[1:0]);
   assign req_tready = state_ff == gto_pkg::ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign is_sample  = act_ff && (req_cmd == gto_pkg::CMD_DATA || req_cmd == gto_pkg::CMD_STOP);
   assign path_sum   = {1'b0, path_ff} + {24'd0, root};
   assign rad_sum    = {1'b0, rad_ff} + {24'd0, root};

   always_comb begin
      unique case (pass_ff)
         gto_pkg::PASS_STEP:   begin ax = in_x_ff;  ay = in_y_ff;  bx = lst_x_ff; by = lst_y_ff; end
         gto_pkg::PASS_RADIUS: begin ax = in_x_ff;  ay = in_y_ff;  bx = org_x_ff; by = org_y_ff; end
         default:              begin ax = stp_x_ff; ay = stp_y_ff; bx = org_x_ff; by = org_y_ff; end
      endcase
      dx = {ax[23], ax} - {bx[23], bx};
      dy = {ay[23], ay} - {by[23], by};
      if (dx[24]) dx = -dx;
      if (dy[24]) dy = -dy;
      mag = (state_ff == gto_pkg::ST_SQ_X) ? dx : dy;
   end

   gto_alu u_alu (
      .clock(clock), .reset(reset),
      .sq_load(sq_load), .sq_add(sq_add), .sq_a(mag),
      .root_start(root_start), .div_start(div_start),
      .div_num(rad_ff), .div_den(cnt_ff),
      .root(root), .quot(quot), .busy(busy)
   );

   always_comb begin
      state_in   = state_ff;
      pass_in    = pass_ff;
      sq_load    = 1'b0;
      sq_add     = 1'b0;
      root_start = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         gto_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = gto_pkg::ST_SQ_X;
               pass_in  = is_sample ? gto_pkg::PASS_STEP : gto_pkg::PASS_END;
            end
         end
         gto_pkg::ST_SQ_X: begin
            sq_load  = 1'b1;
            state_in = gto_pkg::ST_SQ_Y;
         end
         gto_pkg::ST_SQ_Y: begin
            sq_add   = 1'b1;
            state_in = gto_pkg::ST_ROOT;
         end
         gto_pkg::ST_ROOT: begin
            root_start = 1'b1;
            state_in   = gto_pkg::ST_ROOT_WAIT;
         end
         gto_pkg::ST_ROOT_WAIT: begin
            if (!busy) begin
               unique case (pass_ff)
                  gto_pkg::PASS_STEP:   begin pass_in = gto_pkg::PASS_RADIUS;
                                              state_in = gto_pkg::ST_SQ_X; end
                  gto_pkg::PASS_RADIUS: begin pass_in = gto_pkg::PASS_END;
                                              state_in = gto_pkg::ST_SQ_X; end
                  default: state_in = count_ff ? gto_pkg::ST_DIV : gto_pkg::ST_DONE;
               endcase
            end
         end
         gto_pkg::ST_DIV: begin
            div_start = 1'b1;
            state_in  = gto_pkg::ST_DIV_WAIT;
         end
         gto_pkg::ST_DIV_WAIT: begin
            if (!busy) state_in = gto_pkg::ST_DONE;
         end
         gto_pkg::ST_DONE: begin
            if (!rsp_v_ff || rsp_tready) state_in = gto_pkg::ST_IDLE;
         end
         default: state_in = gto_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gto_pkg::ST_IDLE;
         pass_ff  <= gto_pkg::PASS_END;
         org_x_ff <= '0; org_y_ff <= '0; lst_x_ff <= '0; lst_y_ff <= '0;
         stp_x_ff <= '0; stp_y_ff <= '0; act_ff <= 1'b0;
         path_ff <= '0; rad_ff <= '0; cnt_ff <= '0; mean_ff <= '0; e2s_ff <= '0;
         count_ff <= 1'b0; rsp_v_ff <= 1'b0; in_x_ff <= '0; in_y_ff <= '0;
         rsp_data_ff <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         if (accept) begin
            in_x_ff  <= req_tdata[25:2];
            in_y_ff  <= req_tdata[49:26];
            count_ff <= is_sample;
            if (req_cmd == gto_pkg::CMD_START) begin
               org_x_ff <= req_tdata[25:2];
               org_y_ff <= req_tdata[49:26];
               act_ff   <= 1'b1;
            end else if (is_sample && req_cmd == gto_pkg::CMD_STOP) begin
               stp_x_ff <= req_tdata[25:2];
               stp_y_ff <= req_tdata[49:26];
               act_ff   <= 1'b0;
            end
         end
         if (state_ff == gto_pkg::ST_ROOT_WAIT && !busy) begin
            unique case (pass_ff)
               gto_pkg::PASS_STEP: begin
                  path_ff <= path_sum[48] ? gto_pkg::AccMax : path_sum[47:0];
               end
               gto_pkg::PASS_RADIUS: begin
                  rad_ff <= rad_sum[48] ? gto_pkg::AccMax : rad_sum[47:0];
                  if (cnt_ff != gto_pkg::CountMax) cnt_ff <= cnt_ff + 32'd1;
               end
               default: e2s_ff <= root;
            endcase
         end
         if (state_ff == gto_pkg::ST_DIV_WAIT && !busy) begin
            mean_ff <= quot[24:0];
         end
         if (state_ff == gto_pkg::ST_DONE && (!rsp_v_ff || rsp_tready)) begin
            lst_x_ff    <= in_x_ff;
            lst_y_ff    <= in_y_ff;
            rsp_data_ff <= {act_ff, mean_ff, e2s_ff, path_ff, stp_y_ff, stp_x_ff};
            rsp_v_ff    <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != gto_pkg::ST_IDLE |-> !req_tready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_tready |=> rsp_v_ff && $stable(rsp_data_ff))
      else $error("result dropped");
   a_div_den: assert property (@(posedge clock) disable iff (reset)
      div_start |-> cnt_ff != 32'd0) else $error("divide by zero count");
   a_mean: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 32'd0 |-> mean_ff == '0) else $error("mean without samples");
`endif

endmodule

>>> design/gto_alu.sv
// shared unit: square accumulate and one compare-subtract for root and divide steps
module gto_alu (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           sq_load,
   input  logic                           sq_add,
   input  logic [gto_pkg::DiffWidth-1:0]  sq_a,
   input  logic                           root_start,
   input  logic                           div_start,
   input  logic [gto_pkg::AccWidth-1:0]   div_num,
   input  logic [gto_pkg::CountWidth-1:0] div_den,
   output logic [gto_pkg::RootWidth-1:0]  root,
   output logic [gto_pkg::AccWidth-1:0]   quot,
   output logic                           busy
);

   logic [gto_pkg::SqWidth-1:0]  acc_ff, acc_in;
   logic [gto_pkg::RemWidth-1:0] rem_ff, rem_in;
   logic [gto_pkg::AccWidth-1:0] q_ff, q_in;
   logic [5:0]                   cnt_ff, cnt_in;
   gto_pkg::alu_mode_type        mode_ff, mode_in;
   logic [gto_pkg::RemWidth-1:0] shifted, trial;
   logic [gto_pkg::SqWidth-1:0]  prod;

   // square of a 25-bit magnitude
   assign prod = {25'd0, sq_a} * {25'd0, sq_a};
   assign busy = cnt_ff != 6'd0;

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      shifted = '0;
      trial   = '0;
      if (sq_load) begin
         acc_in = prod;
      end else if (sq_add) begin
         acc_in = acc_ff + prod;
      end else if (root_start) begin
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = gto_pkg::RootSteps;
         mode_in = gto_pkg::MODE_ROOT;
      end else if (div_start) begin
         rem_in  = '0;
         q_in    = div_num;
         cnt_in  = gto_pkg::DivSteps;
         mode_in = gto_pkg::MODE_DIV;
      end else if (busy) begin
         cnt_in = cnt_ff - 6'd1;
         if (mode_ff == gto_pkg::MODE_ROOT) begin
            // two radicand bits per step
            shifted = {rem_ff[gto_pkg::RemWidth-3:0], acc_ff[gto_pkg::SqWidth-1 -: 2]};
            trial   = {6'd0, q_ff[gto_pkg::RootWidth-1:0], 2'b01};
            acc_in  = {acc_ff[gto_pkg::SqWidth-3:0], 2'b00};
         end else begin
            shifted = {rem_ff[gto_pkg::RemWidth-2:0], q_ff[gto_pkg::AccWidth-1]};
            trial   = {1'b0, div_den};
         end
         if (shifted >= trial) begin
            rem_in = shifted - trial;
            q_in   = {q_ff[gto_pkg::AccWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[gto_pkg::AccWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         mode_ff <= gto_pkg::MODE_ROOT;
         acc_ff  <= '0;
         rem_ff  <= '0;
         q_ff    <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         rem_ff  <= rem_in;
         q_ff    <= q_in;
      end
   end

   assign root = q_ff[gto_pkg::RootWidth-1:0];
   assign quot = q_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= gto_pkg::DivSteps) else $error("step count out of range");
   a_root_narrow: assert property (@(posedge clock) disable iff (reset)
      mode_ff == gto_pkg::MODE_ROOT |-> q_ff[gto_pkg::AccWidth-1:gto_pkg::RootWidth] == '0)
      else $error("root overflow");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (root_start || div_start) |-> !busy) else $error("start while busy");
   a_load: assert property (@(posedge clock) disable iff (reset)
      root_start |=> cnt_ff == gto_pkg::RootSteps) else $error("root load");
`endif

endmodule
